// File: src/swma_pkg.sv
package swma_pkg;

  // Default sizes of the block.
  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Configuration register width and reset value.
  localparam int               CFG_W            = 7;
  localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic update;
    logic div_step;
    logic load_out;
  } swma_cmd_t;

endpackage

// File: src/swma_in_if.sv
interface swma_in_if import swma_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);

endinterface

// File: src/swma_out_if.sv
interface swma_out_if import swma_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] average;
  logic                           window_full;

  modport source (output valid, output average, output window_full, input ready);
  modport sink (input valid, input average, input window_full, output ready);

endinterface

// File: src/sliding_window_moving_average.sv
// Channel  Direction  Payload                     Handshake
// in_ch    input      sample [SAMPLE_WIDTH]       valid/ready
// out_ch   output     average, window_full        valid/ready
// cfg      input      window_len [7]              cfg_we, no wait
//
// The block takes a new item only once the last one is through its read, update,
// divide and finish steps; the restoring divider produces one quotient bit a
// cycle. The sample memory has one port with a registered read.
// Reset is synchronous and active low; the memory needs no clearing pass.
// A finished result waits in the output register until the sink takes it. The
// next item is still accepted and divided; only its load waits, holding the
// controller in its finish state, so the input stalls once a second result is done.
module sliding_window_moving_average import swma_pkg::*; #(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  swma_in_if.sink          in_ch,
  swma_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  swma_cmd_t cmd;

  // Sequencer for the read, update, divide and output steps.
  swma_ctrl #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Window store, running sum and divider.
  swma_datapath #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .sample      (in_ch.sample),
    .cmd         (cmd),
    .average     (out_ch.average),
    .window_full (out_ch.window_full)
  );

endmodule

// File: src/swma_ctrl.sv
module swma_ctrl import swma_pkg::*; #(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output swma_cmd_t cmd
);

  localparam int SUM_W = SAMPLE_WIDTH + $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(SUM_W);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire;

  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == '0) state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_READ:   ;
      ST_UPDATE: cmd.update = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_FINISH: cmd.load_out = !out_valid_r || out_ready;
      default:   ;
    endcase
  end

  // Quotient bit counter and result valid flag.
  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == ST_UPDATE) begin
      cnt_nxt = CNT_W'(SUM_W - 1);
    end else if (state_r == ST_DIV) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a waiting result");

  // An accepted transfer starts the memory read.
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_READ))
    else $error("accept not followed by read");

  // The division always runs the full number of quotient bits.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |=> (state_r == ST_DIV && cnt_r == CNT_W'(SUM_W - 1)))
    else $error("division started with wrong bit count");

  // A result becomes valid only after the finish state.
  a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result valid without finished division");

endmodule

// File: src/swma_datapath.sv
module swma_datapath import swma_pkg::*; #(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  swma_cmd_t                      cmd,
  output logic signed [SAMPLE_WIDTH-1:0] average,
  output logic                           window_full
);

  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = SAMPLE_WIDTH + $clog2(WINDOW_MAX);

  // Window state.
  logic [CFG_W-1:0]        window_len_r;
  logic [LEN_W-1:0]        fill_r, fill_nxt;
  logic [PTR_W-1:0]        oldest_r, oldest_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;

  // Per-item registers.
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic signed [SAMPLE_WIDTH-1:0] rd_data_r;
  logic [PTR_W-1:0]               slot_r, slot_nxt;
  logic                           filling_r;

  // Divider registers.
  logic [SUM_W-1:0] quo_r;
  logic [LEN_W-1:0] rem_r, div_r;
  logic             neg_r;

  // Result registers.
  logic signed [SAMPLE_WIDTH-1:0] avg_r;
  logic                           full_r;

  logic signed [SAMPLE_WIDTH-1:0] mem [WINDOW_MAX];

  logic [31:0]             len_wide;
  logic [LEN_W-1:0]        len;
  logic                    filling;
  logic [LEN_W:0]          pos, inc;
  logic signed [SUM_W-1:0] old_ext;
  logic [SUM_W-1:0]        sum_mag;
  logic [LEN_W:0]          trial;
  logic                    q_bit;
  logic [LEN_W-1:0]        rem_nxt;
  logic [SUM_W-1:0]        quo_signed;

  // Effective window length: zero acts as one, large values saturate.
  always_comb begin
    priority if (window_len_r == '0) begin
      len_wide = 32'd1;
    end else if (32'(window_len_r) > 32'(WINDOW_MAX)) begin
      len_wide = 32'(WINDOW_MAX);
    end else begin
      len_wide = 32'(window_len_r);
    end
  end
  assign len     = len_wide[LEN_W-1:0];
  assign filling = fill_r < len;

  // Ring slot: while filling, the next free slot after the oldest one; once full, the oldest slot.
  always_comb begin
    pos = (LEN_W+1)'(oldest_r) + (LEN_W+1)'(fill_r);
    if (pos >= (LEN_W+1)'(len)) begin
      pos = pos - (LEN_W+1)'(len);
    end
    slot_nxt = filling ? PTR_W'(pos) : oldest_r;
  end

  // Running sum and window bookkeeping for the item in flight.
  always_comb begin
    old_ext  = filling_r ? '0 : SUM_W'(rd_data_r);
    sum_nxt  = sum_r + SUM_W'(sample_r) - old_ext;
    fill_nxt = filling_r ? fill_r + 1'b1 : fill_r;
    inc      = (LEN_W+1)'(slot_r) + 1'b1;
    if (filling_r) begin
      oldest_nxt = oldest_r;
    end else if (inc == (LEN_W+1)'(len)) begin
      oldest_nxt = '0;
    end else begin
      oldest_nxt = PTR_W'(inc);
    end
    sum_mag = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
  end

  // One restoring division step on the magnitude.
  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    q_bit = trial >= {1'b0, div_r};
    if (q_bit) begin
      rem_nxt = LEN_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[LEN_W-1:0];
    end
    quo_signed = neg_r ? -quo_r : quo_r;
  end

  // Window state registers; a configuration write empties the window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WINDOW_LEN_RESET;
      fill_r       <= '0;
      oldest_r     <= '0;
      sum_r        <= '0;
    end else if (cfg_we) begin
      window_len_r <= cfg_data;
      fill_r       <= '0;
      oldest_r     <= '0;
      sum_r        <= '0;
    end else if (cmd.update) begin
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
      sum_r    <= sum_nxt;
    end
  end

  // Sample memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data_r <= mem[slot_nxt];
    end
    if (cmd.update) begin
      mem[slot_r] <= sample_r;
    end
  end

  // Item capture, divider and result registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r  <= sample;
      slot_r    <= slot_nxt;
      filling_r <= filling;
    end
    if (cmd.update) begin
      quo_r <= sum_mag;
      rem_r <= '0;
      div_r <= fill_nxt;
      neg_r <= sum_nxt[SUM_W-1];
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[SUM_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
    if (cmd.load_out) begin
      avg_r  <= quo_signed[SAMPLE_WIDTH-1:0];
      full_r <= fill_r >= len;
    end
  end

  assign average     = avg_r;
  assign window_full = full_r;

endmodule
